### rtl/core/asid_pkg.sv
// Shared types, field widths and codes of the array search, insert and delete block.
package asid_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int TBL_AW       = 8;   // table address field, wide enough for the largest table
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 2;
    localparam int POS_W        = 5;
    localparam int MIDX_W       = 4;
    localparam int CNT_W        = 5;
    localparam int STAT_W       = 2;

    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic                     found;
        logic [MIDX_W-1:0]        match_index;
        logic [CNT_W-1:0]         used_count;
        logic [STAT_W-1:0]        status;
    } t_out_beat;

    typedef struct packed {
        logic                     we;
        logic [TBL_AW-1:0]        waddr;
        logic [DATA_W-1:0]        wdata;
        logic [TBL_AW-1:0]        raddr;
    } t_tbl_req;

endpackage

### rtl/core/array_search_insert_delete.sv
// Top level: sequencer over the entry table for search, insert and delete.
// An item is taken when start is high and busy is low; its result shows on o_res for one
// cycle with o_strobe, which the receiver cannot stall. The table has one read port, one
// write port and one comparator, so work goes one entry per cycle. Search stays busy after
// the accept cycle while it examines the entries up to and including the match
// (all used entries when none matches). Delete searches the same way, then moves each
// entry above the match down by one. Insert at position p moves entries p-1 to t-1 up
// by one, then writes the value at p-1, t being the used count, or capacity minus one
// when the table is full. A search or delete on an empty table, a bad insert position
// and an unknown command finish in the accept cycle; the result follows in the cycle
// after the accept or after the last busy cycle. No clearing pass runs after reset.
module array_search_insert_delete
    import asid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_beat  i_beat,
    output logic      o_strobe,
    output t_out_beat o_res
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = CW + 2;
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_DSHF = 3'd2;
    localparam logic [2:0] S_ISHF = 3'd3;
    localparam logic [2:0] S_IWR  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [DATA_W-1:0] r_key, n_key;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_hit, n_hit;
    logic [IW-1:0]     r_pm1, n_pm1;
    logic              r_full, n_full;
    logic              r_strobe, n_strobe;
    t_out_beat         r_res, n_res;

    t_tbl_req          tbl_req;
    logic [DATA_W-1:0] tbl_q;
    logic              tbl_eq;

    logic [PW-1:0]     pos_ext;
    logic              bad_pos;
    logic              is_full;
    logic [IW-1:0]     top;
    logic [IW-1:0]     pm1;
    logic [AW-1:0]     idx_ext;
    logic [AW-1:0]     cnt_ext;

    asid_table #(.CAPACITY(CAPACITY)) u_table (
        .i_clk (i_clk),
        .i_req (tbl_req),
        .i_key (r_key),
        .o_q   (tbl_q),
        .o_eq  (tbl_eq)
    );

    assign pos_ext = PW'(i_beat.position);
    assign bad_pos = (pos_ext == '0) || (pos_ext > PW'(r_count) + PW'(1))
                     || (pos_ext > PW'(CAPACITY));
    assign is_full = (r_count == CW'(CAPACITY));
    assign top     = is_full ? IW'(CAPACITY - 1) : IW'(r_count);
    assign pm1     = IW'(pos_ext - PW'(1));
    assign idx_ext = AW'(r_idx);
    assign cnt_ext = AW'(r_count);

    function automatic t_out_beat mk_res(input logic found, input logic [IW-1:0] idx,
                                         input logic [CW-1:0] cnt,
                                         input logic [STAT_W-1:0] st);
        t_out_beat r;
        r.found       = found;
        r.match_index = MIDX_W'(idx);
        r.used_count  = CNT_W'(cnt);
        r.status      = st;
        return r;
    endfunction

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_idx    = r_idx;
        n_hit    = r_hit;
        n_pm1    = r_pm1;
        n_full   = r_full;
        n_strobe = 1'b0;
        n_res    = r_res;
        tbl_req  = '0;

        unique case (r_state)
            S_IDLE: begin
                tbl_req.raddr = (i_beat.command == CMD_INSERT) ? TBL_AW'(top - IW'(1)) : '0;
                if (start) begin
                    n_cmd  = i_beat.command;
                    n_key  = i_beat.value;
                    n_idx  = '0;
                    n_pm1  = pm1;
                    n_full = is_full;
                    priority if (i_beat.command == CMD_SEARCH
                                 || i_beat.command == CMD_DELETE) begin
                        if (r_count == '0) begin
                            n_strobe = 1'b1;
                            n_res    = mk_res(1'b0, '0, r_count, ST_NOTFOUND);
                        end else begin
                            n_state = S_SRCH;
                        end
                    end else if (i_beat.command == CMD_INSERT && !bad_pos) begin
                        n_idx   = top;
                        n_state = (top > pm1) ? S_ISHF : S_IWR;
                    end else begin
                        // bad position or unknown command: nothing changes
                        n_strobe = 1'b1;
                        n_res    = mk_res(1'b0, '0, r_count, ST_BADPOS);
                    end
                end
            end
            S_SRCH: begin
                tbl_req.raddr = TBL_AW'(idx_ext + AW'(1));
                if (tbl_eq) begin
                    n_hit = r_idx;
                    if (r_cmd == CMD_SEARCH) begin
                        n_strobe = 1'b1;
                        n_res    = mk_res(1'b1, r_idx, r_count, ST_DONE);
                        n_state  = S_IDLE;
                    end else if (idx_ext + AW'(1) < cnt_ext) begin
                        n_state = S_DSHF;
                    end else begin
                        n_count  = r_count - CW'(1);
                        n_strobe = 1'b1;
                        n_res    = mk_res(1'b1, r_idx, r_count - CW'(1), ST_DONE);
                        n_state  = S_IDLE;
                    end
                end else if (idx_ext + AW'(1) == cnt_ext) begin
                    n_strobe = 1'b1;
                    n_res    = mk_res(1'b0, '0, r_count, ST_NOTFOUND);
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_DSHF: begin
                // move entry idx+1 down to idx
                tbl_req.we    = 1'b1;
                tbl_req.waddr = TBL_AW'(r_idx);
                tbl_req.wdata = tbl_q;
                tbl_req.raddr = TBL_AW'(idx_ext + AW'(2));
                if (idx_ext + AW'(2) < cnt_ext) begin
                    n_idx = r_idx + IW'(1);
                end else begin
                    n_count  = r_count - CW'(1);
                    n_strobe = 1'b1;
                    n_res    = mk_res(1'b1, r_hit, r_count - CW'(1), ST_DONE);
                    n_state  = S_IDLE;
                end
            end
            S_ISHF: begin
                // move entry idx-1 up to idx
                tbl_req.we    = 1'b1;
                tbl_req.waddr = TBL_AW'(r_idx);
                tbl_req.wdata = tbl_q;
                tbl_req.raddr = TBL_AW'(idx_ext - AW'(2));
                if (idx_ext > AW'(r_pm1) + AW'(1)) begin
                    n_idx = r_idx - IW'(1);
                end else begin
                    n_state = S_IWR;
                end
            end
            S_IWR: begin
                tbl_req.we    = 1'b1;
                tbl_req.waddr = TBL_AW'(r_pm1);
                tbl_req.wdata = r_key;
                n_strobe      = 1'b1;
                n_state       = S_IDLE;
                if (r_full) begin
                    n_res = mk_res(1'b0, '0, r_count, ST_FULL);
                end else begin
                    n_count = r_count + CW'(1);
                    n_res   = mk_res(1'b0, '0, r_count + CW'(1), ST_DONE);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_key  <= n_key;
        r_idx  <= n_idx;
        r_hit  <= n_hit;
        r_pm1  <= n_pm1;
        r_full <= n_full;
        r_res  <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

### rtl/core/asid_table.sv
// Entry memory with one write and one registered read port, plus the shared key comparator.
module asid_table
    import asid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              i_clk,
    input  t_tbl_req          i_req,
    input  logic [DATA_W-1:0] i_key,
    output logic [DATA_W-1:0] o_q,
    output logic              o_eq
);

    localparam int IW = $clog2(CAPACITY);

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[IW-1:0]] <= i_req.wdata;
        end
        r_q <= r_mem[i_req.raddr[IW-1:0]];
    end

    assign o_q  = r_q;
    assign o_eq = (r_q == i_key);

endmodule

### rtl/core/asid_check.sv
// Port-level checker for the array search, insert and delete block, with its bind.
module asid_check
    import asid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_beat  i_beat,
    input logic      o_strobe,
    input t_out_beat o_res
);

    // an accepted beat either finishes at once or holds the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_strobe)
        else $error("accepted beat neither busy nor answered");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while still busy");

    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.found |-> o_res.status == ST_DONE)
        else $error("match reported with non-done status");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.found |-> o_res.match_index == '0)
        else $error("nonzero index without a match");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.status == ST_FULL |-> o_res.used_count == CNT_W'(CAPACITY))
        else $error("drop reported on a table that is not full");

endmodule

bind array_search_insert_delete asid_check #(.CAPACITY(CAPACITY)) u_asid_check (.*);
